/* sv/um32_pkg.sv */
// ----------------------------------------------------------------------------
// UM-32 package
// Shared word width, opcode encoding and run status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package um32_pkg;

  localparam int unsigned WORD_W = 32;

  // Instruction opcodes, bits 31..28 of the instruction word.
  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,
    OP_SLOAD = 4'd1,
    OP_SSTOR = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_MAP   = 4'd8,
    OP_UNMAP = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_LDPRG = 4'd12,
    OP_LDVAL = 4'd13
  } opcode_t;

  // Run status codes.
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

endpackage

`default_nettype wire

/* sv/um32_div.sv */
// ----------------------------------------------------------------------------
// UM-32 divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module um32_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [um32_pkg::WORD_W-1:0] dividend,
  input  wire logic [um32_pkg::WORD_W-1:0] divisor,
  output logic                             done,
  output logic [um32_pkg::WORD_W-1:0]      quotient
);
  import um32_pkg::*;

  localparam int unsigned CW = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] dsr_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [WORD_W:0]   trial;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_r, quo_r[WORD_W-1]} - {1'b0, dsr_r};

  // Iteration counter and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(WORD_W);
        rem_r <= '0;
        quo_r <= dividend;
        dsr_r <= divisor;
      end else if (cnt_r != '0) begin
        if (trial[WORD_W]) begin
          rem_r <= {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        end else begin
          rem_r <= trial[WORD_W-1:0];
        end
        quo_r <= {quo_r[WORD_W-2:0], ~trial[WORD_W]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  // A finished division is only reported once the counter has run out.
  a_done_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> cnt_r == '0) else $error("divider done while still counting");
  // A start always reloads the full count.
  a_start_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == CW'(WORD_W)) else $error("divider count not loaded");
  // Done is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("divider done held");
`endif

endmodule

`default_nettype wire

/* sv/um32_instruction_executor_core.sv */
// ----------------------------------------------------------------------------
// UM-32 instruction executor core
// Eight-register universal machine with bounded segments, driven one beat
// at a time: a beat appends a program word or runs at most one instruction.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Beat contents
//  in_      input      in_valid / in_stall   operation, program word, input byte
//  out_     output     out_valid / out_stall output byte, input used, status, pc
//
// An append goes straight to the reply; most instructions run a fetch from
// the segment memory, three reads of the single register file port, execute
// and reply. Division waits on the bit-serial divider, map zeroes all
// SEG_WORDS words of the new segment, load program copies each word with a
// read then a write, set by the single read and write port of the segment
// memory. Reset is synchronous and takes effect at once; the segment memory
// needs no clearing pass. in_stall stays high from an accepted beat until
// its reply has been taken.
`default_nettype none

module um32_instruction_executor_core #(
  parameter int unsigned NUM_SEGS  = 16,
  parameter int unsigned SEG_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_program_word,
  input  wire logic [7:0]  in_in_byte,
  input  wire logic        in_in_eof,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic             out_in_used,
  output logic [1:0]       out_status,
  output logic [10:0]      out_pc_now
);
  import um32_pkg::*;

  localparam int unsigned IDW = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
  localparam int unsigned FW  = $clog2(NUM_SEGS + 1);
  localparam int unsigned OW  = $clog2(SEG_WORDS);
  localparam int unsigned LW  = $clog2(SEG_WORDS + 1);
  localparam int unsigned AW  = $clog2(NUM_SEGS * SEG_WORDS);
  localparam int unsigned MD  = NUM_SEGS * SEG_WORDS;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_RDC, S_RDB, S_RDA, S_EXEC, S_LDW, S_DIVW,
    S_ZERO, S_CPRD, S_CPWR, S_RESP
  } state_t;

  state_t            state_r;
  logic [31:0]       instr_r;
  logic [31:0]       opa_r, opb_r, opc_r;
  logic [31:0]       rf_r [8];
  logic [LW-1:0]     seg_len_r [NUM_SEGS];
  logic [NUM_SEGS-1:0] mapped_r;
  logic [IDW-1:0]    fq_r [NUM_SEGS];
  logic [IDW-1:0]    q_head_r, q_tail_r;
  logic [FW-1:0]     q_cnt_r;
  logic [FW-1:0]     fresh_r;
  logic [LW-1:0]     pc_r;
  logic [1:0]        stopped_r;
  logic [LW-1:0]     cnt_r, lim_r;
  logic [IDW-1:0]    wid_r;
  logic              ov_r, iu_r;
  logic [7:0]        ob_r, ibyte_r;
  logic              ieof_r;

  logic [31:0]       mem [MD];
  logic [31:0]       mem_rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  logic              in_acc;
  logic [2:0]        rf_sel;
  logic [31:0]       rf_rd;
  logic [31:0]       chk_id, chk_off;
  logic              id_ok, acc_ok;
  opcode_t           opc;
  logic              div_start, div_done;
  logic [31:0]       div_q;
  logic [31:0]       mul_lo;
  logic [IDW-1:0]    map_id;

  function automatic logic [AW-1:0] seg_addr(input logic [IDW-1:0] id,
                                             input logic [OW-1:0] off);
    seg_addr = AW'(id) * AW'(SEG_WORDS) + AW'(off);
  endfunction

  assign in_acc = in_valid && !in_stall;
  assign opc    = opcode_t'(instr_r[31:28]);

  // Single register file read port, stepped through C, B and A.
  always_comb begin
    case (state_r)
      S_RDC:   rf_sel = instr_r[2:0];
      S_RDB:   rf_sel = instr_r[5:3];
      default: rf_sel = instr_r[8:6];
    endcase
  end
  assign rf_rd = rf_r[rf_sel];

  // Segment access check shared by load and store; the id check also serves load program.
  assign chk_id  = (opc == OP_SSTOR) ? opa_r : opb_r;
  assign chk_off = (opc == OP_SSTOR) ? opb_r : opc_r;
  assign id_ok   = (chk_id < 32'(NUM_SEGS)) && mapped_r[chk_id[IDW-1:0]];
  assign acc_ok  = id_ok && (chk_off < 32'(seg_len_r[chk_id[IDW-1:0]]));

  assign mul_lo    = opb_r * opc_r;
  assign map_id    = (q_cnt_r != '0) ? fq_r[q_head_r] : fresh_r[IDW-1:0];
  assign div_start = (state_r == S_EXEC) && (opc == OP_DIV) && (opc_r != '0);

  um32_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opb_r),
    .divisor  (opc_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Segment memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = seg_addr('0, seg_len_r[0][OW-1:0]);
    mem_wdata = in_program_word;
    case (state_r)
      S_EXEC:  mem_raddr = seg_addr(chk_id[IDW-1:0], chk_off[OW-1:0]);
      S_CPRD:  mem_raddr = seg_addr(wid_r, cnt_r[OW-1:0]);
      default: mem_raddr = seg_addr('0, pc_r[OW-1:0]);
    endcase
    case (state_r)
      S_IDLE: begin
        mem_we = in_acc && !in_operation && (seg_len_r[0] < LW'(SEG_WORDS));
      end
      S_EXEC: begin
        mem_we    = (opc == OP_SSTOR) && acc_ok;
        mem_waddr = seg_addr(chk_id[IDW-1:0], chk_off[OW-1:0]);
        mem_wdata = opc_r;
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = seg_addr(wid_r, cnt_r[OW-1:0]);
        mem_wdata = '0;
      end
      S_CPWR: begin
        mem_we    = 1'b1;
        mem_waddr = seg_addr('0, cnt_r[OW-1:0]);
        mem_wdata = mem_rdata_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Segment memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // Sequencer and machine state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      for (int i = 0; i < 8; i++) rf_r[i] <= '0;
      for (int i = 0; i < NUM_SEGS; i++) seg_len_r[i] <= '0;
      mapped_r  <= NUM_SEGS'(1);
      q_head_r  <= '0;
      q_tail_r  <= '0;
      q_cnt_r   <= '0;
      fresh_r   <= FW'(1);
      pc_r      <= '0;
      stopped_r <= ST_RUN;
      ov_r      <= 1'b0;
      iu_r      <= 1'b0;
      ob_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ov_r    <= 1'b0;
            iu_r    <= 1'b0;
            ob_r    <= '0;
            ibyte_r <= in_in_byte;
            ieof_r  <= in_in_eof;
            if (!in_operation) begin
              if (seg_len_r[0] < LW'(SEG_WORDS)) begin
                seg_len_r[0] <= seg_len_r[0] + LW'(1);
              end
              state_r <= S_RESP;
            end else if (stopped_r == ST_RUN && pc_r < seg_len_r[0]) begin
              state_r <= S_FETCH;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_FETCH: begin
          instr_r <= mem_rdata_r;
          state_r <= S_RDC;
        end
        S_RDC: begin
          opc_r   <= rf_rd;
          state_r <= S_RDB;
        end
        S_RDB: begin
          opb_r   <= rf_rd;
          state_r <= S_RDA;
        end
        S_RDA: begin
          opa_r   <= rf_rd;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RESP;
          pc_r    <= pc_r + LW'(1);
          case (opc)
            OP_CMOV: begin
              if (opc_r != '0) rf_r[instr_r[8:6]] <= opb_r;
            end
            OP_SLOAD: begin
              if (acc_ok) begin
                state_r <= S_LDW;
              end else begin
                stopped_r <= ST_FAULT;
                pc_r      <= pc_r;
              end
            end
            OP_SSTOR: begin
              if (!acc_ok) begin
                stopped_r <= ST_FAULT;
                pc_r      <= pc_r;
              end
            end
            OP_ADD:  rf_r[instr_r[8:6]] <= opb_r + opc_r;
            OP_MUL:  rf_r[instr_r[8:6]] <= mul_lo;
            OP_DIV: begin
              if (opc_r == '0) rf_r[instr_r[8:6]] <= '1;
              else state_r <= S_DIVW;
            end
            OP_NAND: rf_r[instr_r[8:6]] <= ~(opb_r & opc_r);
            OP_HALT: begin
              stopped_r <= ST_HALT;
              pc_r      <= pc_r;
            end
            OP_MAP: begin
              if (opc_r > 32'(SEG_WORDS) ||
                  (q_cnt_r == '0 && fresh_r >= FW'(NUM_SEGS))) begin
                stopped_r <= ST_FAULT;
                pc_r      <= pc_r;
              end else begin
                if (q_cnt_r != '0) begin
                  q_head_r <= (q_head_r == IDW'(NUM_SEGS - 1)) ? '0
                                                              : q_head_r + IDW'(1);
                  q_cnt_r  <= q_cnt_r - FW'(1);
                end else begin
                  fresh_r <= fresh_r + FW'(1);
                end
                seg_len_r[map_id]  <= opc_r[LW-1:0];
                mapped_r[map_id]   <= 1'b1;
                rf_r[instr_r[5:3]] <= 32'(map_id);
                wid_r              <= map_id;
                cnt_r              <= '0;
                state_r            <= S_ZERO;
              end
            end
            OP_UNMAP: begin
              if (opc_r == '0 || opc_r >= 32'(NUM_SEGS) ||
                  !mapped_r[opc_r[IDW-1:0]]) begin
                stopped_r <= ST_FAULT;
                pc_r      <= pc_r;
              end else begin
                mapped_r[opc_r[IDW-1:0]]  <= 1'b0;
                seg_len_r[opc_r[IDW-1:0]] <= '0;
                fq_r[q_tail_r]            <= opc_r[IDW-1:0];
                q_tail_r <= (q_tail_r == IDW'(NUM_SEGS - 1)) ? '0
                                                            : q_tail_r + IDW'(1);
                q_cnt_r  <= q_cnt_r + FW'(1);
              end
            end
            OP_OUT: begin
              if (opc_r > 32'd255) begin
                stopped_r <= ST_FAULT;
                pc_r      <= pc_r;
              end else begin
                ov_r <= 1'b1;
                ob_r <= opc_r[7:0];
              end
            end
            OP_IN: begin
              iu_r               <= 1'b1;
              rf_r[instr_r[2:0]] <= ieof_r ? '1 : 32'(ibyte_r);
            end
            OP_LDPRG: begin
              pc_r <= (opc_r > 32'(SEG_WORDS)) ? LW'(SEG_WORDS) : opc_r[LW-1:0];
              if (opb_r != '0) begin
                if (!id_ok) begin
                  stopped_r <= ST_FAULT;
                  pc_r      <= pc_r;
                end else begin
                  seg_len_r[0] <= seg_len_r[opb_r[IDW-1:0]];
                  lim_r        <= seg_len_r[opb_r[IDW-1:0]];
                  wid_r        <= opb_r[IDW-1:0];
                  cnt_r        <= '0;
                  if (seg_len_r[opb_r[IDW-1:0]] != '0) state_r <= S_CPRD;
                end
              end
            end
            OP_LDVAL: rf_r[instr_r[27:25]] <= {7'd0, instr_r[24:0]};
            default: begin
              stopped_r <= ST_FAULT;
              pc_r      <= pc_r;
            end
          endcase
        end
        S_LDW: begin
          rf_r[instr_r[8:6]] <= mem_rdata_r;
          state_r            <= S_RESP;
        end
        S_DIVW: begin
          if (div_done) begin
            rf_r[instr_r[8:6]] <= div_q;
            state_r            <= S_RESP;
          end
        end
        S_ZERO: begin
          cnt_r <= cnt_r + LW'(1);
          if (cnt_r == LW'(SEG_WORDS - 1)) state_r <= S_RESP;
        end
        S_CPRD: begin
          state_r <= S_CPWR;
        end
        S_CPWR: begin
          cnt_r <= cnt_r + LW'(1);
          if (cnt_r + LW'(1) == lim_r) state_r <= S_RESP;
          else state_r <= S_CPRD;
        end
        S_RESP: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Reply beat, held in registers until taken.
  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_RESP);
  assign out_out_valid = ov_r;
  assign out_out_byte  = ob_r;
  assign out_in_used   = iu_r;
  assign out_status    = (stopped_r != ST_RUN) ? stopped_r
                       : (pc_r >= seg_len_r[0]) ? ST_HALT : ST_RUN;
  assign out_pc_now    = 11'(pc_r);

`ifndef SYNTHESIS
  // A stopped machine never runs again.
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r != ST_RUN |=> stopped_r == $past(stopped_r))
    else $error("stopped state changed");
  // The program counter does not move on a fault.
  a_fault_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r != ST_FAULT ##1 stopped_r == ST_FAULT) |-> $stable(pc_r))
    else $error("pc moved on fault");
  // The free id queue never holds more ids than there are segments.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= FW'(NUM_SEGS)) else $error("free id queue overflow");
  // A reply that emits a byte never also consumes input, and the machine has not stopped.
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_valid) |-> (!out_in_used && stopped_r == ST_RUN))
    else $error("inconsistent reply beat");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// UM-32 instruction executor core testbench
// Loads programs one beat at a time and runs them instruction by instruction.
// Every reply is checked against an in-bench machine model or a typed row;
// a short directed table comes first. Generated programs follow, kept clear
// of faults until a final stopping instruction. Sender gaps and receiver
// stalls vary by phase, and one long receiver hold-off backs the core up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import um32_pkg::*;

  localparam int NUM_SEGS  = 16;
  localparam int SEG_WORDS = 1024;
  localparam int LIMIT     = 3000000;

  typedef struct {
    bit         ov;
    logic [7:0] ob;
    bit         iu;
    logic [1:0] st;
    logic [10:0] pc;
  } reply_t;

  typedef struct {
    bit          op;
    logic [31:0] w;
    logic [7:0]  ib;
    bit          eof;
    bit          typed;
    reply_t      r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [31:0] in_program_word = '0;
  logic [7:0]  in_in_byte = '0;
  logic        in_in_eof = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_in_used;
  logic [1:0]  out_status;
  logic [10:0] out_pc_now;

  // Machine model state.
  logic [31:0] regs [8];
  logic [31:0] seg_mem [NUM_SEGS*SEG_WORDS];
  int          seg_len [NUM_SEGS];
  bit          seg_mapped [NUM_SEGS];
  int          free_ids [NUM_SEGS];
  int          free_head, free_count, fresh_id, prog_ctr;
  logic [1:0]  run_state;

  reply_t   expected_replies [$];
  dir_row_t directed_beats [$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       cycles = 0;
  int       send_idle = 0;
  int       recv_stall = 0;
  int       hold_left = 0;
  bit       held = 1'b0;

  um32_instruction_executor_core #(.NUM_SEGS(NUM_SEGS), .SEG_WORDS(SEG_WORDS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_program_word(in_program_word),
    .in_in_byte(in_in_byte), .in_in_eof(in_in_eof),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_out_valid(out_out_valid), .out_out_byte(out_out_byte),
    .out_in_used(out_in_used), .out_status(out_status), .out_pc_now(out_pc_now)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit id_ok(logic [31:0] id);
    return id < NUM_SEGS && seg_mapped[id[3:0]];
  endfunction

  // Advances the machine model by one beat and returns the reply it gives.
  function automatic reply_t um32_step(bit op, logic [31:0] w, logic [7:0] ib, bit eof);
    reply_t      r;
    logic [31:0] iw;
    logic [1:0]  s;
    bit          advance;
    int          a, b, c, id, len;
    r = '{0, 8'd0, 0, ST_RUN, 11'd0};
    if (!op) begin
      if (seg_len[0] < SEG_WORDS) begin
        seg_mem[seg_len[0]] = w;
        seg_len[0]++;
      end
    end else if (run_state == ST_RUN && prog_ctr < seg_len[0]) begin
      iw = seg_mem[prog_ctr];
      a = iw[8:6]; b = iw[5:3]; c = iw[2:0];
      s = ST_RUN;
      advance = 1'b1;
      case (opcode_t'(iw[31:28]))
        OP_CMOV:  if (regs[c] != 0) regs[a] = regs[b];
        OP_SLOAD: begin
          if (!id_ok(regs[b]) || regs[c] >= seg_len[regs[b][3:0]]) s = ST_FAULT;
          else regs[a] = seg_mem[regs[b][3:0]*SEG_WORDS + regs[c]];
        end
        OP_SSTOR: begin
          if (!id_ok(regs[a]) || regs[b] >= seg_len[regs[a][3:0]]) s = ST_FAULT;
          else seg_mem[regs[a][3:0]*SEG_WORDS + regs[b]] = regs[c];
        end
        OP_ADD:   regs[a] = regs[b] + regs[c];
        OP_MUL:   regs[a] = regs[b] * regs[c];
        OP_DIV:   regs[a] = (regs[c] == 0) ? 32'hFFFF_FFFF : regs[b] / regs[c];
        OP_NAND:  regs[a] = ~(regs[b] & regs[c]);
        OP_HALT:  s = ST_HALT;
        OP_MAP: begin
          id = -1;
          if (regs[c] > SEG_WORDS) s = ST_FAULT;
          else if (free_count > 0) begin
            id = free_ids[free_head];
            free_head = (free_head + 1) % NUM_SEGS;
            free_count--;
          end else if (fresh_id < NUM_SEGS) begin
            id = fresh_id;
            fresh_id++;
          end else s = ST_FAULT;
          if (s == ST_RUN) begin
            for (int k = 0; k < SEG_WORDS; k++) seg_mem[id*SEG_WORDS + k] = '0;
            seg_len[id] = regs[c];
            seg_mapped[id] = 1'b1;
            regs[b] = id;
          end
        end
        OP_UNMAP: begin
          if (regs[c] == 0 || !id_ok(regs[c])) s = ST_FAULT;
          else begin
            id = regs[c];
            seg_mapped[id] = 1'b0;
            seg_len[id] = 0;
            free_ids[(free_head + free_count) % NUM_SEGS] = id;
            free_count++;
          end
        end
        OP_OUT: begin
          if (regs[c] > 255) s = ST_FAULT;
          else begin
            r.ov = 1'b1;
            r.ob = regs[c][7:0];
          end
        end
        OP_IN: begin
          r.iu = 1'b1;
          regs[c] = eof ? 32'hFFFF_FFFF : {24'd0, ib};
        end
        OP_LDPRG: begin
          if (regs[b] != 0 && !id_ok(regs[b])) s = ST_FAULT;
          else begin
            if (regs[b] != 0) begin
              id = regs[b];
              len = seg_len[id];
              for (int k = 0; k < len; k++) seg_mem[k] = seg_mem[id*SEG_WORDS + k];
              seg_len[0] = len;
            end
            prog_ctr = (regs[c] > SEG_WORDS) ? SEG_WORDS : regs[c];
            advance = 1'b0;
          end
        end
        OP_LDVAL: regs[iw[27:25]] = {7'd0, iw[24:0]};
        default:  s = ST_FAULT;
      endcase
      if (s != ST_RUN) begin
        run_state = s;
        r.ov = 1'b0; r.ob = 8'd0; r.iu = 1'b0;
      end else if (advance) prog_ctr++;
    end
    if (run_state != ST_RUN) r.st = run_state;
    else r.st = (prog_ctr >= seg_len[0]) ? ST_HALT : ST_RUN;
    r.pc = prog_ctr[10:0];
    return r;
  endfunction

  // True when the word, once appended and executed, keeps the machine running
  // and leaves the pc at the end of segment 0 or at most five words past it.
  function automatic bit runs_clean(logic [31:0] w);
    int a, b, c, t, lim;
    a = w[8:6]; b = w[5:3]; c = w[2:0];
    case (opcode_t'(w[31:28]))
      OP_SLOAD: return id_ok(regs[b]) && regs[c] < seg_len[regs[b][3:0]];
      OP_SSTOR: return id_ok(regs[a]) && regs[b] < seg_len[regs[a][3:0]];
      OP_HALT:  return 1'b0;
      OP_MAP:   return regs[c] <= 40 && (free_count > 0 || fresh_id < NUM_SEGS);
      OP_UNMAP: return regs[c] != 0 && id_ok(regs[c]);
      OP_OUT:   return regs[c] <= 255;
      OP_LDPRG: begin
        if (regs[b] != 0 && !id_ok(regs[b])) return 1'b0;
        if (regs[c] > SEG_WORDS) return 1'b0;
        t = regs[c];
        lim = (regs[b] == 0) ? seg_len[0] + 1 : seg_len[regs[b][3:0]];
        return t >= lim && t <= lim + 5;
      end
      OP_CMOV, OP_ADD, OP_MUL, OP_DIV, OP_NAND, OP_IN, OP_LDVAL: return 1'b1;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] ins(opcode_t o, int a, int b, int c);
    return {o, 19'($urandom), 3'(a), 3'(b), 3'(c)};
  endfunction

  function automatic logic [31:0] ldv(int a, logic [31:0] v);
    return {OP_LDVAL, 3'(a), v[24:0]};
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 15);
      2: return $urandom_range(0, 40);
      3: return $urandom;
      default: return seg_len[0] + 1 + $urandom_range(0, 2);
    endcase
  endfunction

  // Sends one beat and records the reply it should produce.
  task automatic send_beat(bit op, logic [31:0] w, logic [7:0] ib, bit eof,
                           bit typed, reply_t tv);
    reply_t p;
    bit     ok;
    p = um32_step(op, w, ib, eof);
    expected_replies.push_back(typed ? tv : p);
    case ((beats_sent / 60) % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 46; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 46; end
      default: begin send_idle = 36; recv_stall = 36; end
    endcase
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_program_word <= w;
    in_in_byte      <= ib;
    in_in_eof       <= eof;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    beats_sent++;
  endtask

  task automatic send_pair(logic [31:0] w, logic [7:0] ib, bit eof);
    reply_t none;
    none = '{0, 8'd0, 0, ST_RUN, 11'd0};
    send_beat(1'b0, w, $urandom, $urandom, 1'b0, none);
    send_beat(1'b1, $urandom, ib, eof, 1'b0, none);
  endtask

  // Receiver: random stalls, plus one long hold-off once traffic is flowing.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && beats_sent >= 250) begin
      held      <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall);
    end
  end

  // Reply checking, sampled between edges.
  always @(negedge clk) begin
    reply_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected reply at cycle %0d", cycles);
      end else begin
        e = expected_replies.pop_front();
        if (out_out_valid !== e.ov || out_out_byte !== e.ob || out_in_used !== e.iu ||
            out_status !== e.st || out_pc_now !== e.pc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Reply mismatch: expected ov=%0d byte=%02h used=%0d st=%0d pc=%0d, got ov=%0d byte=%02h used=%0d st=%0d pc=%0d",
                     e.ov, e.ob, e.iu, e.st, e.pc, out_out_valid, out_out_byte,
                     out_in_used, out_status, out_pc_now);
        end
      end
    end
  end

  initial begin
    reply_t      none;
    logic [31:0] w;
    int          tries;
    none = '{0, 8'd0, 0, ST_RUN, 11'd0};
    for (int i = 0; i < 8; i++) regs[i] = '0;
    for (int i = 0; i < NUM_SEGS; i++) begin
      seg_len[i] = 0; seg_mapped[i] = 1'b0; free_ids[i] = 0;
    end
    seg_mapped[0] = 1'b1;
    free_head = 0; free_count = 0; fresh_id = 1; prog_ctr = 0;
    run_state = ST_RUN;

    // Directed beats: empty program, extremes and every opcode that keeps the machine
    // running but load program, including division by zero and end of input.
    directed_beats.push_back('{1, 32'hFFFF_FFFF, 8'hFF, 1, 1, '{0, 8'd0, 0, ST_HALT, 11'd0}});
    directed_beats.push_back('{0, ldv(1, 32'h01FF_FFFF), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 1, '{0, 8'd0, 0, ST_HALT, 11'd1}});
    directed_beats.push_back('{0, ldv(2, 0), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_DIV, 3, 1, 2), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_MUL, 4, 1, 1), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_NAND, 5, 2, 2), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_ADD, 6, 5, 1), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_CMOV, 6, 5, 2), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_IN, 0, 0, 6), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h5A, 1, 0, none});
    directed_beats.push_back('{0, ins(OP_IN, 0, 0, 7), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'hFF, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_OUT, 0, 0, 7), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_MAP, 0, 3, 7), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_SSTOR, 3, 2, 1), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_SLOAD, 0, 3, 2), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});
    directed_beats.push_back('{0, ins(OP_UNMAP, 0, 0, 3), 8'h00, 0, 0, none});
    directed_beats.push_back('{1, 32'h0, 8'h00, 0, 0, none});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_beats[i])
      send_beat(directed_beats[i].op, directed_beats[i].w, directed_beats[i].ib,
                directed_beats[i].eof, directed_beats[i].typed, directed_beats[i].r);

    // Generated programs: each instruction is appended and then executed.
    // Words past the end after a jump are filler that never runs.
    while (beats_sent < 560 && seg_len[0] < SEG_WORDS - 8) begin
      if (prog_ctr > seg_len[0]) begin
        send_beat(1'b0, $urandom, $urandom, $urandom, 1'b0, none);
        if ($urandom_range(0, 3) == 0)
          send_beat(1'b1, $urandom, $urandom, $urandom, 1'b0, none);
      end else if ($urandom_range(0, 19) == 0) begin
        send_beat(1'b1, $urandom, $urandom, $urandom, 1'b0, none);
      end else begin
        tries = 0;
        do begin
          if ($urandom_range(0, 2) == 0) w = ldv($urandom_range(0, 7), pick_value());
          else w = ins(opcode_t'($urandom_range(0, 13)), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 7));
          tries++;
        end while (!runs_clean(w) && tries < 8);
        if (!runs_clean(w)) w = ldv($urandom_range(0, 7), pick_value());
        send_pair(w, $urandom, ($urandom_range(0, 7) == 0));
      end
    end

    // Close with one stopping instruction, then show that the machine stays put.
    while (prog_ctr > seg_len[0]) send_beat(1'b0, $urandom, 8'h00, 0, 1'b0, none);
    send_pair(ldv(0, 32'h01FF_FFFF), 8'h00, 0);
    case ($urandom_range(0, 5))
      0: w = ins(OP_HALT, 0, 0, 0);
      1: w = {3'b111, 29'($urandom)};
      2: w = ins(OP_OUT, 0, 0, 0);
      3: w = ins(OP_UNMAP, 0, 0, 0);
      4: w = ins(OP_MAP, 0, 1, 0);
      default: w = ins(OP_LDPRG, 0, 0, 1);
    endcase
    send_pair(w, $urandom, 0);
    send_beat(1'b1, $urandom, $urandom, 0, 1'b0, none);
    send_pair(ins(OP_ADD, 1, 1, 1), $urandom, 0);
    in_valid <= 1'b0;

    while (expected_replies.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_replies.size() > 0) mismatches++;

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/um32_pkg.sv
sv/um32_div.sv
sv/um32_instruction_executor_core.sv
tb/tb.sv
